// ===== rtl/impsq_pkg.sv =====
package impsq_pkg;

    // Input opcodes
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_BUS_DONE = 2'd1;
    localparam logic [1:0] OP_LOAD_SP  = 2'd2;

    // Bus actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_RESTART   = 3'd3;
    localparam logic [2:0] ACT_WRITE     = 3'd4;
    localparam logic [2:0] ACT_READ_ACK  = 3'd5;
    localparam logic [2:0] ACT_READ_NACK = 3'd6;

    // Report kinds
    localparam logic [1:0] RPT_NONE     = 2'd0;
    localparam logic [1:0] RPT_ABSENT   = 2'd1;
    localparam logic [1:0] RPT_READBACK = 2'd2;
    localparam logic [1:0] RPT_WR_NACK  = 2'd3;

    // Bus controller status codes and other constants
    localparam logic [7:0] STATUS_DATA_NACK = 8'h30;
    localparam logic [7:0] STATUS_RADDR_ACK = 8'h40;
    localparam logic [7:0] ADDR_BASE_RST    = 8'h52;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [2:0] {
        PH_WR_ADDR   = 3'd0,
        PH_WR_DATA   = 3'd1,
        PH_WR_END    = 3'd2,
        PH_RD_ADDR   = 3'd3,
        PH_RD_FIRST  = 3'd4,
        PH_RD_SECOND = 3'd5
    } t_phase;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [3:0] lost_motor;
        logic [7:0] error_count;
        logic [7:0] second_byte;
        logic [7:0] first_byte;
        logic [2:0] report_motor;
        logic [1:0] report_kind;
        logic [7:0] tx_byte;
        logic [2:0] bus_action;
    } t_result;

endpackage

// ===== rtl/i2c_motor_poll_sequencer_core.sv =====
// I2C master sequencer for a bank of motor controllers.
// Slave channel: one transfer per event. tuser carries the opcode (start round,
// bus event done, load setpoint); tdata carries bus status, received byte and
// the setpoint index/value. Master channel: one result transfer per accepted
// input, telling the bus controller what to do next (start, stop, restart,
// write byte, read with/without ack) plus an optional report (motor absent,
// readback complete, setpoint write nacked) and the latched missing motor.
// Configuration: i_cfg_wr_en writes the bus address of motor zero; motor k is
// written at base+2k and read at base+1+2k. Write only while idle.
// The result of an item is registered and on the master side in the cycle after
// it is accepted. Throughput: one item per cycle unless the receiver stalls; the
// phase update is a short combinational path from state to the output register.
// The output register decouples the sides: a new item is taken whenever the
// output register is empty or its transfer completes in the same cycle.
// When the receiver stalls, the result holds and tready drops until it leaves.
// Reset (synchronous, active low) clears phase, positions, setpoints, NACK
// counts and readback bytes, empties the output register and loads the
// address base with 0x52.
module i2c_motor_poll_sequencer_core #(
    parameter int MOTOR_COUNT = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [7:0]                   i_cfg_wr_data,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [7:0] bus_status, [15:8] rx_byte, [18:16] setpoint_index,
    // [26:19] setpoint_value, [31:27] zero
    input  logic [impsq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                   i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [2:0] bus_action, [10:3] tx_byte, [12:11] report_kind,
    // [15:13] report_motor, [23:16] first_byte, [31:24] second_byte,
    // [39:32] error_count, [43:40] lost_motor, [47:44] zero
    output logic [impsq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import impsq_pkg::*;

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam logic [3:0] MC_W = 4'(MOTOR_COUNT);

    // input fields
    logic [1:0] opcode;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
    logic [2:0] sp_index;
    logic [7:0] sp_value;

    assign opcode     = i_s_axis_tuser;
    assign bus_status = i_s_axis_tdata[7:0];
    assign rx_byte    = i_s_axis_tdata[15:8];
    assign sp_index   = i_s_axis_tdata[18:16];
    assign sp_value   = i_s_axis_tdata[26:19];

    // state
    logic [7:0] r_base;
    t_phase     r_phase, n_phase;
    logic [3:0] r_wr_pos, n_wr_pos;
    logic [2:0] r_rd_pos, n_rd_pos;
    logic [3:0] r_first_missing, n_first_missing;
    logic [3:0] r_missing_latched, n_missing_latched;
    logic [7:0] r_setpoints [MOTOR_COUNT];
    logic [7:0] r_nack_counts [MOTOR_COUNT];
    logic [7:0] r_rb_first [MOTOR_COUNT];

    logic    r_out_valid;
    t_result r_out, n_out;

    logic accept;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // shared decode of the current position
    logic             wr_in_range, rd_in_range, sp_in_range, nack_hit;
    logic [3:0]       wr_prev;
    logic [IDX_W-1:0] wr_idx, prev_idx, rd_idx, sp_idx;
    logic [7:0]       cur_setpoint, nack_next, rb_first_cur;
    logic [2:0]       rd_next;
    logic [3:0]       rd_inc;

    assign wr_in_range = r_wr_pos < MC_W;
    assign rd_in_range = {1'b0, r_rd_pos} < MC_W;
    assign sp_in_range = {1'b0, sp_index} < MC_W;
    assign wr_prev     = r_wr_pos - 4'd1;
    assign wr_idx      = r_wr_pos[IDX_W-1:0];
    assign prev_idx    = wr_prev[IDX_W-1:0];
    assign rd_idx      = r_rd_pos[IDX_W-1:0];
    assign sp_idx      = sp_index[IDX_W-1:0];

    // data NACK on a setpoint byte that belongs to a real motor
    assign nack_hit = (bus_status == STATUS_DATA_NACK) && (r_wr_pos != 4'd0)
                   && (wr_prev < MC_W);

    assign cur_setpoint = wr_in_range ? r_setpoints[wr_idx] : 8'd0;
    assign rb_first_cur = rd_in_range ? r_rb_first[rd_idx] : 8'd0;
    assign nack_next    = (r_nack_counts[prev_idx] == COUNT_MAX) ? COUNT_MAX
                        : r_nack_counts[prev_idx] + 8'd1;

    // rotate the polled motor
    assign rd_inc  = {1'b0, r_rd_pos} + 4'd1;
    assign rd_next = (rd_inc >= MC_W) ? 3'd0 : rd_inc[2:0];

    // next state of the sequencer
    always_comb begin
        n_phase           = r_phase;
        n_wr_pos          = r_wr_pos;
        n_rd_pos          = r_rd_pos;
        n_first_missing   = r_first_missing;
        n_missing_latched = r_missing_latched;
        if (opcode == OP_START) begin
            n_phase  = PH_WR_ADDR;
            n_wr_pos = 4'd0;
        end else if (opcode == OP_BUS_DONE) begin
            unique case (r_phase)
                PH_WR_ADDR: begin
                    if (!wr_in_range) begin
                        n_wr_pos = 4'd0;
                        n_phase  = PH_RD_ADDR;
                    end else begin
                        n_phase = PH_WR_DATA;
                    end
                end
                PH_WR_DATA: begin
                    n_wr_pos = r_wr_pos + 4'd1;
                    n_phase  = PH_WR_END;
                end
                PH_WR_END: begin
                    if (nack_hit && r_first_missing == 4'd0) begin
                        n_first_missing = r_wr_pos;
                    end
                    n_phase = PH_WR_ADDR;
                end
                PH_RD_ADDR: begin
                    if (bus_status != STATUS_RADDR_ACK) begin
                        n_rd_pos = rd_next;
                        n_phase  = PH_WR_ADDR;
                    end else begin
                        n_phase = PH_RD_FIRST;
                    end
                    n_missing_latched = r_first_missing;
                    n_first_missing   = 4'd0;
                end
                PH_RD_FIRST: begin
                    n_phase = PH_RD_SECOND;
                end
                PH_RD_SECOND: begin
                    n_rd_pos = rd_next;
                    n_phase  = PH_WR_ADDR;
                end
                default: begin
                    n_phase = PH_WR_ADDR;
                end
            endcase
        end
    end

    // result of the accepted item
    always_comb begin
        n_out            = '0;
        n_out.lost_motor = n_missing_latched;
        if (opcode == OP_START) begin
            n_out.bus_action = ACT_START;
        end else if (opcode == OP_BUS_DONE) begin
            unique case (r_phase)
                PH_WR_ADDR: begin
                    n_out.bus_action = ACT_WRITE;
                    if (!wr_in_range) begin
                        n_out.tx_byte = r_base + 8'd1 + {4'd0, r_rd_pos, 1'b0};
                    end else begin
                        n_out.tx_byte = r_base + {3'd0, r_wr_pos, 1'b0};
                    end
                end
                PH_WR_DATA: begin
                    n_out.bus_action = ACT_WRITE;
                    n_out.tx_byte    = cur_setpoint;
                end
                PH_WR_END: begin
                    n_out.bus_action = ACT_RESTART;
                    if (nack_hit) begin
                        n_out.report_kind  = RPT_WR_NACK;
                        n_out.report_motor = wr_prev[2:0];
                        n_out.error_count  = nack_next;
                    end
                end
                PH_RD_ADDR: begin
                    if (bus_status != STATUS_RADDR_ACK) begin
                        n_out.bus_action   = ACT_STOP;
                        n_out.report_kind  = RPT_ABSENT;
                        n_out.report_motor = r_rd_pos;
                    end else begin
                        n_out.bus_action = ACT_READ_ACK;
                    end
                end
                PH_RD_FIRST: begin
                    n_out.bus_action = ACT_READ_NACK;
                end
                PH_RD_SECOND: begin
                    n_out.bus_action   = ACT_STOP;
                    n_out.report_kind  = RPT_READBACK;
                    n_out.report_motor = r_rd_pos;
                    n_out.first_byte   = rb_first_cur;
                    n_out.second_byte  = rx_byte;
                end
                default: begin
                    n_out.bus_action = ACT_NONE;
                end
            endcase
        end
    end

    // control state and per-motor tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base            <= ADDR_BASE_RST;
            r_phase           <= PH_WR_ADDR;
            r_wr_pos          <= 4'd0;
            r_rd_pos          <= 3'd0;
            r_first_missing   <= 4'd0;
            r_missing_latched <= 4'd0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                r_setpoints[i]   <= 8'd0;
                r_nack_counts[i] <= 8'd0;
                r_rb_first[i]    <= 8'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            if (accept) begin
                r_phase           <= n_phase;
                r_wr_pos          <= n_wr_pos;
                r_rd_pos          <= n_rd_pos;
                r_first_missing   <= n_first_missing;
                r_missing_latched <= n_missing_latched;
                if (opcode == OP_LOAD_SP && sp_in_range) begin
                    r_setpoints[sp_idx] <= sp_value;
                end
                if (opcode == OP_BUS_DONE && r_phase == PH_WR_END && nack_hit) begin
                    r_nack_counts[prev_idx] <= nack_next;
                end
                if (opcode == OP_BUS_DONE && r_phase == PH_RD_FIRST && rd_in_range) begin
                    r_rb_first[rd_idx] <= rx_byte;
                end
            end
        end
    end

    // output register: load on accept, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_out};

endmodule
